### sv/japanese_charset_transcoder_core_defines.svh
// ----------------------------------------------------------------------------
// Japanese charset transcoder - assertion macros
// Shared concurrent assertion forms for the transcoder checkers.
// ----------------------------------------------------------------------------
`ifndef JAPANESE_CHARSET_TRANSCODER_CORE_DEFINES_SVH
`define JAPANESE_CHARSET_TRANSCODER_CORE_DEFINES_SVH

// Property checked out of reset only.
`define JCT_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define JCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/jct_pkg.sv
// ----------------------------------------------------------------------------
// Japanese charset transcoder - package
// Mode codes, byte constants, output queue sizing and pair conversions.
// ----------------------------------------------------------------------------
package jct_pkg;

  // Conversion selected by the mode register
  typedef enum logic [1:0] {
    MODE_EUC_SJ = 2'd0,
    MODE_SJ_EUC = 2'd1,
    MODE_ISO_SJ = 2'd2,
    MODE_COPY   = 2'd3
  } mode_e;

  // Byte values
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PAREN  = 8'h28;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] SS2       = 8'h8e;
  localparam logic [7:0] ASCII_TOP = 8'h80;
  localparam logic [7:0] HI_LO     = 8'ha1;
  localparam logic [7:0] KANA_HI   = 8'hdf;
  localparam logic [7:0] EUC_HI    = 8'hfe;
  localparam logic [7:0] JIS_MASK  = 8'h7f;

  // Results per input byte and output queue (depth is a power of two)
  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  // JIS row/cell pair to Shift_JIS lead/trail, returned as {lead, trail}
  function automatic logic [15:0] jis_to_sj(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] lead;
    logic [7:0] trail;
    logic [8:0] sum;
    if (hi[0]) begin
      trail = lo + ((lo < 8'h60) ? 8'h1f : 8'h20);
    end else begin
      trail = lo + 8'h7e;
    end
    if (hi < 8'h5f) begin
      sum  = {1'b0, hi} + 9'h0e1;
      lead = sum[8:1];
    end else begin
      sum  = {1'b0, hi} + 9'h061;
      lead = sum[8:1] | 8'h80;
    end
    return {lead, trail};
  endfunction

  // Shift_JIS lead/trail pair to EUC-JP, returned as {first, second}
  function automatic logic [15:0] sj_to_euc(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] base;
    base = hi - 8'hb0;
    if (hi <= 8'h9f) begin
      first = {hi[6:0], 1'b0} - ((lo < 8'h9f) ? 8'he1 : 8'he0);
    end else begin
      first = {base[6:0], 1'b0} - ((lo < 8'h9f) ? 8'h01 : 8'h00);
    end
    if (lo < 8'h7f) begin
      second = lo - 8'h1f;
    end else if (lo < 8'h9f) begin
      second = lo - 8'h20;
    end else begin
      second = lo - 8'h7e;
    end
    return {first | 8'h80, second | 8'h80};
  endfunction

endpackage

### sv/japanese_charset_transcoder_core.sv
// ----------------------------------------------------------------------------
// Japanese charset transcoder - top level
// Byte stream converter: EUC-JP to Shift_JIS, Shift_JIS to EUC-JP, ISO-2022-JP to Shift_JIS.
// ----------------------------------------------------------------------------
// One source byte is taken per beat on the input channel and turned, in the
// same cycle, into zero to three output bytes that are written into a
// four-entry output queue; results are offered from the registered queue,
// which drains one beat per cycle unless stalled. A byte is accepted
// whenever the queue holds at most one beat, which gives one byte per cycle
// while each byte yields at most one result and the output side keeps up;
// bytes that expand (kana prefix, flushed escapes, terminator flush) are
// paced by the single output read port. The mode register may only be
// written while the block is idle; a write discards held bytes and returns
// ISO-2022-JP decoding to ASCII. A zero byte ends a string: held bytes are
// flushed (an unpaired lead byte is dropped), the zero is passed on, and
// the decoding state is cleared.
// ----------------------------------------------------------------------------
module japanese_charset_transcoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_conversion_mode_i,
  // source byte channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  // result byte channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import jct_pkg::*;

  // State
  mode_e                 mode_q;
  logic [7:0]            held_q [2];
  logic [1:0]            held_cnt_q;
  logic                  kanji_q;

  // Per-byte decode results
  logic [7:0]            res_byte [MAX_RES];
  logic [1:0]            res_cnt;
  logic [7:0]            held0_d;
  logic [7:0]            held1_d;
  logic [1:0]            held_cnt_d;
  logic                  kanji_d;

  // Pair conversions feeding the decoder
  logic [15:0]           pair_euc;
  logic [15:0]           pair_iso_in;
  logic [15:0]           pair_iso_held;
  logic [15:0]           pair_sj;

  // Output queue
  logic [8:0]            oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0]      oq_wp_q;
  logic [OQ_AW-1:0]      oq_rp_q;
  logic [OQ_CW-1:0]      oq_cnt_q;
  logic                  in_beat;
  logic                  out_beat;

  logic [7:0]            b;
  logic [7:0]            h0;
  logic [7:0]            h1;

  assign b  = in_byte_i;
  assign h0 = held_q[0];
  assign h1 = held_q[1];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (oq_cnt_q <= OQ_CW'(OQ_DEPTH - MAX_RES));
  assign in_beat     = in_valid_i & in_ready_o;
  assign out_valid_o = (oq_cnt_q != '0);
  assign out_beat    = out_valid_o & out_ready_i;

  assign pair_euc      = jis_to_sj(h0 & JIS_MASK, b & JIS_MASK);
  assign pair_iso_in   = jis_to_sj(h0, b);
  assign pair_iso_held = jis_to_sj(h0, h1);
  assign pair_sj       = sj_to_euc(h0, b);

  // Decode one source byte against the held bytes
  always_comb begin
    res_byte[0] = b;
    res_byte[1] = b;
    res_byte[2] = b;
    res_cnt     = 2'd0;
    held0_d     = h0;
    held1_d     = h1;
    held_cnt_d  = held_cnt_q;
    kanji_d     = kanji_q;

    if (b == CH_NUL) begin
      // terminator: flush what ISO-2022-JP holds, then pass the zero on
      held_cnt_d  = 2'd0;
      kanji_d     = 1'b0;
      res_byte[0] = CH_NUL;
      res_cnt     = 2'd1;
      if (mode_q == MODE_ISO_SJ) begin
        if (!kanji_q && held_cnt_q == 2'd2) begin
          res_byte[0] = h0;
          res_byte[1] = h1;
          res_byte[2] = CH_NUL;
          res_cnt     = 2'd3;
        end else if (!kanji_q && held_cnt_q == 2'd1) begin
          res_byte[0] = h0;
          res_byte[1] = CH_NUL;
          res_cnt     = 2'd2;
        end else if (kanji_q && held_cnt_q == 2'd2) begin
          res_byte[0] = pair_iso_held[15:8];
          res_byte[1] = pair_iso_held[7:0];
          res_byte[2] = CH_NUL;
          res_cnt     = 2'd3;
        end
      end
    end else begin
      case (mode_q)
        MODE_EUC_SJ: begin
          if (held_cnt_q != 2'd0) begin
            held_cnt_d = 2'd0;
            if (h0 == SS2) begin
              res_cnt = 2'd1;
            end else begin
              res_byte[0] = pair_euc[15:8];
              res_byte[1] = pair_euc[7:0];
              res_cnt     = 2'd2;
            end
          end else if (b == SS2 || (b >= HI_LO && b <= EUC_HI)) begin
            held0_d    = b;
            held_cnt_d = 2'd1;
          end else begin
            res_cnt = 2'd1;
          end
        end
        MODE_SJ_EUC: begin
          if (held_cnt_q != 2'd0) begin
            held_cnt_d  = 2'd0;
            res_byte[0] = pair_sj[15:8];
            res_byte[1] = pair_sj[7:0];
            res_cnt     = 2'd2;
          end else if (b <= ASCII_TOP) begin
            res_cnt = 2'd1;
          end else if (b >= HI_LO && b <= KANA_HI) begin
            res_byte[0] = SS2;
            res_cnt     = 2'd2;
          end else begin
            held0_d    = b;
            held_cnt_d = 2'd1;
          end
        end
        MODE_ISO_SJ: begin
          if (!kanji_q) begin
            // ASCII: copy, holding any escape prefix
            case (held_cnt_q)
              2'd0: begin
                if (b == CH_ESC) begin
                  held0_d    = b;
                  held_cnt_d = 2'd1;
                end else begin
                  res_cnt = 2'd1;
                end
              end
              2'd1: begin
                if (b == CH_DOLLAR || b == CH_PAREN) begin
                  held1_d    = b;
                  held_cnt_d = 2'd2;
                end else if (b == CH_ESC) begin
                  res_byte[0] = h0;
                  res_cnt     = 2'd1;
                  held0_d     = b;
                  held_cnt_d  = 2'd1;
                end else begin
                  res_byte[0] = h0;
                  res_cnt     = 2'd2;
                  held_cnt_d  = 2'd0;
                end
              end
              2'd2: begin
                if (b == CH_B) begin
                  kanji_d    = (h1 == CH_DOLLAR);
                  held_cnt_d = 2'd0;
                end else if (b == CH_ESC) begin
                  res_byte[0] = h0;
                  res_byte[1] = h1;
                  res_cnt     = 2'd2;
                  held0_d     = b;
                  held_cnt_d  = 2'd1;
                end else begin
                  res_byte[0] = h0;
                  res_byte[1] = h1;
                  res_cnt     = 2'd3;
                  held_cnt_d  = 2'd0;
                end
              end
              default: begin
                held_cnt_d = 2'd0;
              end
            endcase
          end else begin
            // kanji: pair bytes, still watching for escapes
            case (held_cnt_q)
              2'd0: begin
                held0_d    = b;
                held_cnt_d = 2'd1;
              end
              2'd1: begin
                if (h0 == CH_ESC && (b == CH_DOLLAR || b == CH_PAREN)) begin
                  held1_d    = b;
                  held_cnt_d = 2'd2;
                end else begin
                  res_byte[0] = pair_iso_in[15:8];
                  res_byte[1] = pair_iso_in[7:0];
                  res_cnt     = 2'd2;
                  held_cnt_d  = 2'd0;
                end
              end
              2'd2: begin
                if (b == CH_B) begin
                  kanji_d    = (h1 == CH_DOLLAR);
                  held_cnt_d = 2'd0;
                end else begin
                  res_byte[0] = pair_iso_held[15:8];
                  res_byte[1] = pair_iso_held[7:0];
                  res_cnt     = 2'd2;
                  held0_d     = b;
                  held_cnt_d  = 2'd1;
                end
              end
              default: begin
                held_cnt_d = 2'd0;
              end
            endcase
          end
        end
        default: begin
          // plain copy
          res_cnt = 2'd1;
        end
      endcase
    end
  end

  // Mode register and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_EUC_SJ;
      held_cnt_q <= 2'd0;
      kanji_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q     <= mode_e'(cfg_conversion_mode_i);
      held_cnt_q <= 2'd0;
      kanji_q    <= 1'b0;
    end else if (in_beat) begin
      held_cnt_q <= held_cnt_d;
      kanji_q    <= kanji_d;
    end
  end

  // Held byte payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      held_q[0] <= held0_d;
      held_q[1] <= held1_d;
    end
  end

  // Output queue storage: up to three beats written per accepted byte
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < res_cnt) begin
          oq_mem[oq_wp_q + OQ_AW'(k)] <= {res_byte[k], (2'(k) == res_cnt - 2'd1)};
        end
      end
    end
  end

  // Output queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (in_beat) begin
        oq_wp_q <= oq_wp_q + OQ_AW'(res_cnt);
      end
      if (out_beat) begin
        oq_rp_q <= oq_rp_q + OQ_AW'(1);
      end
      oq_cnt_q <= oq_cnt_q + (in_beat ? OQ_CW'(res_cnt) : '0) - OQ_CW'(out_beat);
    end
  end

  assign out_byte_o = oq_mem[oq_rp_q][8:1];
  assign out_last_o = oq_mem[oq_rp_q][0];

endmodule

### sv/jct_checker.sv
// ----------------------------------------------------------------------------
// Japanese charset transcoder - port checker
// Watches the top level ports; attached to the core by a bind statement.
// ----------------------------------------------------------------------------
`include "japanese_charset_transcoder_core_defines.svh"

module jct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // a stalled result beat stays offered
  `JCT_ASSERT_RUN(a_out_hold, clk_i, rst_ni,
                  out_valid_o && !out_ready_i |=> out_valid_o,
                  "result beat withdrawn while stalled")

  // a stalled result beat keeps its payload
  `JCT_ASSERT_RUN(a_out_stable, clk_i, rst_ni,
                  out_valid_o && !out_ready_i |=> $stable(out_byte_o) && $stable(out_last_o),
                  "result payload changed while stalled")

  // a waiting source beat stays offered with its byte unchanged
  `JCT_ASSERT_RUN(a_in_hold, clk_i, rst_ni,
                  in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i),
                  "source beat changed while waiting")

  // an empty output queue always has room for a source byte
  `JCT_ASSERT_RUN(a_in_room, clk_i, rst_ni,
                  !out_valid_o |-> in_ready_o,
                  "input stalled with empty output queue")

  // nothing is offered in the cycle after reset is seen
  `JCT_ASSERT_ALWAYS(a_rst_quiet, clk_i,
                     !rst_ni |=> !out_valid_o,
                     "result offered during reset")

endmodule

bind japanese_charset_transcoder_core jct_checker u_jct_checker (.*);
